@@ design/sma_pkg.sv @@
// ----------------------------------------------------------------------------
// sma_pkg: shared types and constants of the stack machine arithmetic unit
// Word width, opcode and status codes, cell commands and divider status.
// ----------------------------------------------------------------------------
package sma_pkg;

	// data word and stack size
	localparam int WORD_W          = 32;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int DIV_STEPS       = WORD_W;

	// widths of the opcode, status and character fields
	localparam int OP_W   = 3;
	localparam int ST_W   = 3;
	localparam int CHAR_W = 7;
	localparam int DEPTH_OUT_W = 7;

	// opcodes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 3'd0,
		OP_SUB   = 3'd1,
		OP_DIV   = 3'd2,
		OP_MUL   = 3'd3,
		OP_MOD   = 3'd4,
		OP_PCHAR = 3'd5
	} op_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_DIV0  = 3'd2,
		ST_EMPTY = 3'd3,
		ST_RANGE = 3'd4,
		ST_FULL  = 3'd5
	} status_t;

	// what a stack cell loads on the next edge
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_ABOVE = 2'd1,
		CELL_BELOW = 2'd2
	} cell_cmd_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ design/sma_cell.sv @@
// ----------------------------------------------------------------------------
// sma_cell: one entry of the shifting stack
// Holds a word, or takes the word of the neighbor above or below it.
// ----------------------------------------------------------------------------
module sma_cell
	import sma_pkg::*;
(
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [WORD_W-1:0] above_data,
	input  logic [WORD_W-1:0] below_data,
	output logic [WORD_W-1:0] data
);

	logic [WORD_W-1:0] data_q;

	// entry register, no reset: contents are undefined until pushed
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_ABOVE: data_q <= above_data;
			CELL_BELOW: data_q <= below_data;
			default:    data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

@@ design/sma_div.sv @@
// ----------------------------------------------------------------------------
// sma_div: iterative signed restoring divider
// One quotient bit per cycle on magnitudes, signs fixed up at the output.
// ----------------------------------------------------------------------------
module sma_div
	import sma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic [WORD_W-1:0] quotient,
	output logic [WORD_W-1:0] remainder,
	output div_stat_t         stat
);

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic              qneg_q;
	logic              rneg_q;

	logic [WORD_W-1:0] dvd_mag;
	logic [WORD_W-1:0] dvs_mag;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;

	// magnitudes of the operands; the most negative word maps to itself unsigned
	assign dvd_mag = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
	assign dvs_mag = divisor[WORD_W-1]  ? (~divisor + 1'b1)  : divisor;

	// one restoring step
	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_LAST;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dvd_mag;
			dvs_q  <= dvs_mag;
			qneg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			rneg_q <= dividend[WORD_W-1];
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
			end else begin
				rem_q <= trial[WORD_W-1:0];
			end
			quo_q <= {quo_q[WORD_W-2:0], ~diff[WORD_W]};
		end
	end

	// sign fix-up: quotient truncates toward zero, remainder follows dividend
	assign quotient  = qneg_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = rneg_q ? (~rem_q + 1'b1) : rem_q;

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ design/stack_machine_arith_unit_top.sv @@
// ----------------------------------------------------------------------------
// stack_machine_arith_unit_top: bounded word stack with an arithmetic unit
// Push, sub, mul, pchar, unused opcodes and errors give a registered result word, with a new
// word taken every cycle while the output is not stalled; div and mod run the 32 restoring
// divider steps, then commit their word once the output is free, and stall the input until that commit.
// Reset clears the depth, the sequencer, the divider control and the output valid;
// stack entries are undefined until pushed.
// ----------------------------------------------------------------------------
module stack_machine_arith_unit_top
	import sma_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [OP_W-1:0]        opcode,
	input  logic signed [WORD_W-1:0] push_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ST_W-1:0]        status,
	output logic                   char_valid,
	output logic [CHAR_W-1:0]      char_code,
	output logic [DEPTH_OUT_W-1:0] depth_after
);

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] FULL_CNT = DEPTH_W'(STACK_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DIV  = 2'b10
	} state_t;

	state_t state_q, state_nxt;

	logic [DEPTH_W-1:0]     depth_q, depth_nxt;
	logic                   out_valid_q;
	status_t                status_q, st_nxt;
	logic                   char_valid_q, cv_nxt;
	logic [CHAR_W-1:0]      char_code_q, cc_nxt;
	logic [DEPTH_OUT_W-1:0] depth_out_q, depth_out_nxt;
	logic                   is_mod_q;

	logic                   in_acc;
	logic                   out_free;
	logic                   out_load;
	logic                   div_start;
	logic                   div_commit;
	cell_cmd_t              cmd_top;
	cell_cmd_t              cmd_rest;
	logic [WORD_W-1:0]      load_data;
	logic [WORD_W-1:0]      tos;
	logic [WORD_W-1:0]      nos;
	logic [2*WORD_W-1:0]    prod;
	logic [WORD_W-1:0]      quotient;
	logic [WORD_W-1:0]      remainder;
	div_stat_t              div_stat;
	logic [DEPTH_W+DEPTH_OUT_W-1:0] depth_ext;

	logic [WORD_W-1:0]      cell_data [STACK_DEPTH];

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// top two entries and the combinational units
	assign tos  = cell_data[0];
	assign nos  = cell_data[1];
	assign prod = nos * tos;

	assign div_commit = (state_q == S_DIV) && div_stat.done && out_free;

	// sequencer and cell commands
	always_comb begin
		state_nxt = state_q;
		depth_nxt = depth_q;
		cmd_top   = CELL_HOLD;
		cmd_rest  = CELL_HOLD;
		load_data = push_value;
		out_load  = 1'b0;
		div_start = 1'b0;
		st_nxt    = ST_OK;
		cv_nxt    = 1'b0;
		cc_nxt    = '0;
		if (in_acc) begin
			out_load = 1'b1;
			case (opcode)
				OP_PUSH: begin
					if (depth_q == FULL_CNT) begin
						st_nxt = ST_FULL;
					end else begin
						cmd_top   = CELL_ABOVE;
						cmd_rest  = CELL_ABOVE;
						depth_nxt = depth_q + 1'b1;
					end
				end
				OP_SUB, OP_MUL: begin
					if (depth_q < DEPTH_W'(2)) begin
						st_nxt = ST_SHORT;
					end else begin
						load_data = (opcode == OP_SUB) ? (nos - tos) : prod[WORD_W-1:0];
						cmd_top   = CELL_ABOVE;
						cmd_rest  = CELL_BELOW;
						depth_nxt = depth_q - 1'b1;
					end
				end
				OP_DIV, OP_MOD: begin
					if (depth_q < DEPTH_W'(2)) begin
						st_nxt = ST_SHORT;
					end else if (tos == '0) begin
						st_nxt = ST_DIV0;
					end else begin
						out_load  = 1'b0;
						div_start = 1'b1;
						state_nxt = S_DIV;
					end
				end
				OP_PCHAR: begin
					if (depth_q == '0) begin
						st_nxt = ST_EMPTY;
					end else if (tos[WORD_W-1:CHAR_W] != '0) begin
						st_nxt = ST_RANGE;
					end else begin
						cv_nxt = 1'b1;
						cc_nxt = tos[CHAR_W-1:0];
					end
				end
				default: begin
					st_nxt = ST_OK;
				end
			endcase
		end else if (div_commit) begin
			out_load  = 1'b1;
			load_data = is_mod_q ? remainder : quotient;
			cmd_top   = CELL_ABOVE;
			cmd_rest  = CELL_BELOW;
			depth_nxt = depth_q - 1'b1;
			state_nxt = S_IDLE;
		end
	end

	// depth reported as its low bits
	assign depth_ext     = {{DEPTH_OUT_W{1'b0}}, depth_nxt};
	assign depth_out_nxt = depth_ext[DEPTH_OUT_W-1:0];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			depth_q <= depth_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word and pending operation
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= st_nxt;
			char_valid_q <= cv_nxt;
			char_code_q  <= cc_nxt;
			depth_out_q  <= depth_out_nxt;
		end
		if (div_start) begin
			is_mod_q <= (opcode == OP_MOD);
		end
	end

	// row of stack cells, entry 0 is the top of stack
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] above_w;
		logic [WORD_W-1:0] below_w;
		cell_cmd_t         cmd_w;
		if (i == 0) begin : g_first
			assign above_w = load_data;
			assign cmd_w   = cmd_top;
		end else begin : g_mid
			assign above_w = cell_data[i-1];
			assign cmd_w   = cmd_rest;
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign below_w = '0;
		end else begin : g_inner
			assign below_w = cell_data[i+1];
		end
		sma_cell u_cell (
			.clk        (clk),
			.cmd        (cmd_w),
			.above_data (above_w),
			.below_data (below_w),
			.data       (cell_data[i])
		);
	end

	// divider for div and mod
	sma_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (nos),
		.divisor   (tos),
		.quotient  (quotient),
		.remainder (remainder),
		.stat      (div_stat)
	);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign char_valid  = char_valid_q;
	assign char_code   = char_code_q;
	assign depth_after = depth_out_q;

	// depth never passes the stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= FULL_CNT)
		else $error("stack depth above stack size");

	// depth moves only on an accepted word or a divider commit
	a_depth_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc || div_commit) |=> $stable(depth_q))
		else $error("stack depth changed without an operation");

	// a started division keeps the divider busy on the next cycle
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (div_stat.busy && state_q == S_DIV))
		else $error("divider not running after start");

	// no new word is taken while a division is pending
	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !in_acc)
		else $error("word accepted during division");

endmodule
